// ----- rtl/dust_sensor_frame_decoder_assert.svh -----
// Assertion macros for the dust sensor frame decoder checker.
// Plain text macros, no dependencies.
`ifndef DUST_SENSOR_FRAME_DECODER_ASSERT_SVH
`define DUST_SENSOR_FRAME_DECODER_ASSERT_SVH

// Implication property, sampled on the rising clock, off during reset.
`define DSFD_ASSERT_IMPL(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be seen while out of reset.
`define DSFD_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ----- rtl/dsfd_pkg.sv -----
// Shared constants for the dust sensor frame decoder.
// No dependencies.
package dsfd_pkg;

  localparam int unsigned FrameLen = 8;   // header + data + checksum, 6..32
  localparam int unsigned CntW     = $clog2(FrameLen);

  localparam logic [7:0]      HeaderReset = 8'hA5;
  localparam logic [CntW-1:0] PosInt      = CntW'(3);
  localparam logic [CntW-1:0] PosDec      = CntW'(4);
  localparam logic [CntW-1:0] PosChk      = CntW'(FrameLen - 1);

  localparam int unsigned DutyW = 15;     // 100*255 + 255 fits
  localparam int unsigned PmW   = 13;

  localparam logic [PmW-1:0]   PmMax    = 13'd6400;
  localparam logic [DutyW-1:0] DutyLow  = 15'd50;    // at or below: 0
  localparam logic [DutyW-1:0] DutyHigh = 15'd5000;  // above: PmMax

  // floor(t/99) == (t*RecipM) >> RecipShift for t < 2^20
  localparam int unsigned RecipShift = 27;
  localparam logic [20:0] RecipM     = 21'd1355735;

endpackage

// ----- rtl/dsfd_rx_if.sv -----
// Byte input channel of the dust sensor frame decoder.
// No dependencies.
interface dsfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/dsfd_cfg_if.sv -----
// Configuration write channel (header byte register).
// No dependencies.
interface dsfd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;

  modport source (output valid, output header_byte, input ready);
  modport sink   (input valid, input header_byte, output ready);
endinterface

// ----- rtl/dsfd_reading_if.sv -----
// Result channel of the dust sensor frame decoder.
// Depends on dsfd_pkg.
interface dsfd_reading_if;
  logic                       valid;
  logic                       ready;
  logic                       reading_valid;
  logic [dsfd_pkg::PmW-1:0]   pm25_sixteenths;

  modport source (output valid, output reading_valid, output pm25_sixteenths, input ready);
  modport sink   (input valid, input reading_valid, input pm25_sixteenths, output ready);
endinterface

// ----- rtl/dust_sensor_frame_decoder.sv -----
// Dust sensor frame decoder top level: framing, checksum, result register.
// Depends on dsfd_pkg, dsfd_rx_if, dsfd_cfg_if, dsfd_reading_if, dsfd_pm_calc.
//
//   port       dir   transaction
//   rx_i       in    one received byte
//   cfg_i      in    header byte register write (always ready)
//   reading_o  out   one result per completed frame: checksum ok flag + pm
//
// One byte per cycle. A frame's result is registered on the edge that takes its
// checksum byte and shows in the next cycle. The duty is formed when byte 4 arrives,
// so the checksum cycle only runs the divide-by-99 multiplier and the clamp.
// rx_i stalls only while a result waits and reading_o.ready is low.
// Reset returns to hunting for the header; header register resets to 0xA5.
module dust_sensor_frame_decoder (
  input  logic           clk_i,
  input  logic           rst_ni,
  dsfd_rx_if.sink        rx_i,
  dsfd_cfg_if.sink       cfg_i,
  dsfd_reading_if.source reading_o
);

  logic                          header_q;
  logic [7:0]                    header_byte_q;
  logic                          in_frame_q, in_frame_d;
  logic [dsfd_pkg::CntW-1:0]     count_q, count_d;
  logic [7:0]                    sum_q, sum_d;
  logic [7:0]                    integer_q, integer_d;
  logic [dsfd_pkg::DutyW-1:0]    duty_q, duty_d;
  logic [dsfd_pkg::PmW-1:0]      last_q, last_d;
  logic                          out_valid_q, out_valid_d;
  logic                          out_ok_q, out_ok_d;
  logic [dsfd_pkg::PmW-1:0]      pm;
  logic                          rx_fire;
  logic [7:0]                    b;
  logic [7:0]                    chk_sum;

  assign header_q = 1'b1;
  assign cfg_i.ready = header_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_byte_q <= dsfd_pkg::HeaderReset;
    end else if (cfg_i.valid) begin
      header_byte_q <= cfg_i.header_byte;
    end
  end

  assign b        = rx_i.rx_byte;
  assign rx_i.ready = !out_valid_q || reading_o.ready;
  assign rx_fire  = rx_i.valid && rx_i.ready;
  assign chk_sum  = sum_q + b;

  dsfd_pm_calc u_pm_calc (
    .duty_i (duty_q),
    .pm_o   (pm)
  );

  always_comb begin
    in_frame_d  = in_frame_q;
    count_d     = count_q;
    sum_d       = sum_q;
    integer_d   = integer_q;
    duty_d      = duty_q;
    last_d      = last_q;
    out_ok_d    = out_ok_q;
    out_valid_d = out_valid_q && !reading_o.ready;

    if (rx_fire) begin
      if (!in_frame_q) begin
        if (b == header_byte_q) begin
          in_frame_d = 1'b1;
          count_d    = dsfd_pkg::CntW'(1);
          sum_d      = '0;
        end
      end else if (count_q == dsfd_pkg::PosChk) begin
        // checksum byte: two's complement of the data sum
        out_valid_d = 1'b1;
        out_ok_d    = (chk_sum == 8'h00);
        if (chk_sum == 8'h00) begin
          last_d = pm;
        end
        in_frame_d = 1'b0;
        count_d    = '0;
      end else begin
        sum_d   = chk_sum;
        count_d = count_q + dsfd_pkg::CntW'(1);
        if (count_q == dsfd_pkg::PosInt) begin
          integer_d = b;
        end
        if (count_q == dsfd_pkg::PosDec) begin
          duty_d = dsfd_pkg::DutyW'(integer_q) * 15'd100 + dsfd_pkg::DutyW'(b);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q  <= 1'b0;
      count_q     <= '0;
      sum_q       <= '0;
      integer_q   <= '0;
      duty_q      <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
      out_ok_q    <= 1'b0;
    end else begin
      in_frame_q  <= in_frame_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      integer_q   <= integer_d;
      duty_q      <= duty_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      out_ok_q    <= out_ok_d;
    end
  end

  // last good reading doubles as the result payload register
  assign reading_o.valid           = out_valid_q;
  assign reading_o.reading_valid   = out_ok_q;
  assign reading_o.pm25_sixteenths = last_q;

endmodule

// ----- rtl/dsfd_pm_calc.sv -----
// Duty (hundredths) to PM2.5 concentration in 1/16 units, clamped.
// pm = floor((duty - 50) * 128 / 99), limited to 0..6400. Depends on dsfd_pkg.
module dsfd_pm_calc (
  input  logic [dsfd_pkg::DutyW-1:0] duty_i,
  output logic [dsfd_pkg::PmW-1:0]   pm_o
);

  logic [12:0] excess;
  logic [19:0] scaled;
  logic [40:0] prod;

  // Only used when 50 < duty <= 5000, so excess stays below 4951.
  assign excess = 13'(duty_i - dsfd_pkg::DutyLow);
  assign scaled = {excess, 7'b0};
  assign prod   = 41'(scaled) * 41'(dsfd_pkg::RecipM);

  always_comb begin
    if (duty_i <= dsfd_pkg::DutyLow) begin
      pm_o = '0;
    end else if (duty_i > dsfd_pkg::DutyHigh) begin
      pm_o = dsfd_pkg::PmMax;
    end else begin
      pm_o = prod[dsfd_pkg::RecipShift +: dsfd_pkg::PmW];
    end
  end

endmodule

// ----- rtl/dsfd_checker.sv -----
// Port-level checks for the dust sensor frame decoder, bound to the top level.
// Depends on dsfd_pkg and dust_sensor_frame_decoder_assert.svh.
`include "dust_sensor_frame_decoder_assert.svh"

module dsfd_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     rx_valid_i,
  input logic                     rx_ready_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic                     out_ok_i,
  input logic [dsfd_pkg::PmW-1:0] out_pm_i
);

  `DSFD_ASSERT_IMPL(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_ok_i) && $stable(out_pm_i), "result changed while stalled")

  `DSFD_ASSERT_NEVER(a_pm_range, clk_i, rst_ni, out_valid_i && out_pm_i > dsfd_pkg::PmMax, "reading above 400 units")

  `DSFD_ASSERT_NEVER(a_no_take_stalled, clk_i, rst_ni, out_valid_i && !out_ready_i && rx_ready_i, "byte taken while result stalled")

  `DSFD_ASSERT_IMPL(a_result_cause, clk_i, rst_ni, out_valid_i && (!$past(out_valid_i) || $past(out_ready_i)) |-> $past(rx_valid_i && rx_ready_i), "new result without a byte")

endmodule

bind dust_sensor_frame_decoder dsfd_checker u_dsfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rx_valid_i  (rx_i.valid),
  .rx_ready_i  (rx_i.ready),
  .out_valid_i (reading_o.valid),
  .out_ready_i (reading_o.ready),
  .out_ok_i    (reading_o.reading_valid),
  .out_pm_i    (reading_o.pm25_sixteenths)
);
